### design/binomial_coefficient_top_assert.svh
// Assertion macros for the binomial coefficient block.
`ifndef BINOMIAL_COEFFICIENT_TOP_ASSERT_SVH
`define BINOMIAL_COEFFICIENT_TOP_ASSERT_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define BC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define BC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/bc_pkg.sv
// Shared constants and types of the binomial coefficient block.
package bc_pkg;

  localparam int ROW_W  = 6;
  localparam int K_W    = 7;
  localparam int COEF_W = 59;
  localparam int ACC_W  = 64;
  localparam int IDX_W  = 5;
  localparam int CNT_W  = 6;

  localparam logic [ROW_W-1:0] MAX_N     = ROW_W'(62);
  localparam logic [CNT_W-1:0] MUL_LAST  = CNT_W'(ROW_W - 1);
  localparam logic [CNT_W-1:0] DIV_LAST  = CNT_W'(ACC_W - 1);

  // Request to the multiply-divide unit.
  typedef struct packed {
    logic             start;
    logic [ROW_W-1:0] factor;
    logic [IDX_W-1:0] divisor;
  } bc_mdu_req_t;

  // Status from the multiply-divide unit.
  typedef struct packed {
    logic busy;
    logic done;
  } bc_mdu_rsp_t;

endpackage

### design/binomial_coefficient_top.sv
// Top level of the binomial coefficient block: sequencer around the shared unit.
//
//   channel | ports                                   | direction
//   --------+-----------------------------------------+----------
//   in      | in_valid, in_ready, in_row_n, in_choose_k | into block
//   out     | out_valid, out_ready, out_coefficient    | out of block
//
// The work for one word takes m steps, where m = min(k, n-k), at most 31.
// Each of the m steps issues a request to the shared multiply-divide unit,
// which runs a shift-add multiply and then a restoring division, after
// which the sequencer takes the quotient into its accumulator. Out-of-range
// words and words with m = 0 skip the steps and go straight to the final step.
// Reset clears the sequencer and the output valid flag; nothing else needs it.
// The block takes a new word while a finished result still waits in the
// output register, and a stalled output only holds the sequencer at its
// final step.
module binomial_coefficient_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [bc_pkg::ROW_W-1:0]      in_row_n,
  input  logic signed [bc_pkg::K_W-1:0] in_choose_k,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [bc_pkg::COEF_W-1:0]     out_coefficient
);
  import bc_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_ISSUE, ST_WAIT, ST_FINISH} state_t;

  state_t              state_r, state_nxt;
  logic [ROW_W-1:0]    n_r, n_nxt;
  logic [IDX_W-1:0]    kk_r, kk_nxt;
  logic [IDX_W-1:0]    i_r, i_nxt;
  logic [ACC_W-1:0]    acc_r, acc_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [COEF_W-1:0]   out_coef_r, out_coef_nxt;

  bc_mdu_req_t         mdu_req;
  bc_mdu_rsp_t         mdu_rsp;
  logic [ACC_W-1:0]    mdu_quot;

  // Range check and folding of k to min(k, n-k) on the incoming word.
  logic [ROW_W-1:0]    k_mag;
  logic [ROW_W-1:0]    n_minus_k;
  logic [ROW_W-1:0]    k_min;
  logic                k_bad;

  assign k_mag     = in_choose_k[ROW_W-1:0];
  assign n_minus_k = in_row_n - k_mag;
  assign k_min     = (k_mag > n_minus_k) ? n_minus_k : k_mag;
  assign k_bad     = in_choose_k[K_W-1] || (in_row_n > MAX_N) || (k_mag > in_row_n);

  // Step i multiplies by n-i+1 and then divides exactly by i.
  assign mdu_req.start   = (state_r == ST_ISSUE);
  assign mdu_req.factor  = n_r - {1'b0, i_r} + ROW_W'(1);
  assign mdu_req.divisor = i_r;

  bc_mdu u_mdu (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (mdu_req),
    .operand  (acc_r),
    .rsp      (mdu_rsp),
    .quotient (mdu_quot)
  );

  always_comb begin
    state_nxt     = state_r;
    n_nxt         = n_r;
    kk_nxt        = kk_r;
    i_nxt         = i_r;
    acc_nxt       = acc_r;
    out_valid_nxt = out_valid_r;
    out_coef_nxt  = out_coef_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          n_nxt  = in_row_n;
          kk_nxt = k_min[IDX_W-1:0];
          i_nxt  = IDX_W'(1);
          // Zero for an out-of-range word, one before any step.
          acc_nxt = k_bad ? '0 : ACC_W'(1);
          if (k_bad || (k_min == '0)) begin
            state_nxt = ST_FINISH;
          end else begin
            state_nxt = ST_ISSUE;
          end
        end
      end
      ST_ISSUE: begin
        state_nxt = ST_WAIT;
      end
      ST_WAIT: begin
        if (mdu_rsp.done) begin
          acc_nxt = mdu_quot;
          if (i_r == kk_r) begin
            state_nxt = ST_FINISH;
          end else begin
            i_nxt     = i_r + 1'b1;
            state_nxt = ST_ISSUE;
          end
        end
      end
      ST_FINISH: begin
        // Load the output register as soon as it is free.
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_coef_nxt  = acc_r[COEF_W-1:0];
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    n_r        <= n_nxt;
    kk_r       <= kk_nxt;
    i_r        <= i_nxt;
    acc_r      <= acc_nxt;
    out_coef_r <= out_coef_nxt;
  end

  assign in_ready        = (state_r == ST_IDLE);
  assign out_valid       = out_valid_r;
  assign out_coefficient = out_coef_r;

`include "binomial_coefficient_top_assert.svh"

  `BC_ASSERT_NXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "accepted word did not make the block busy")
  `BC_ASSERT_IMP(a_start_when_free, mdu_req.start, !mdu_rsp.busy, "shared unit started while busy")
  `BC_ASSERT_NXT(a_neg_k_short, in_valid && in_ready && in_choose_k[K_W-1], state_r == ST_FINISH, "negative k did not take the short path")
  `BC_ASSERT_IMP(a_result_from_finish, $rose(out_valid), $past(state_r == ST_FINISH), "result appeared outside the final step")

endmodule

### design/bc_mdu.sv
// Iterative multiply-then-divide unit: quotient = (operand * factor) / divisor.
module bc_mdu (
  input  logic                       clk,
  input  logic                       rst_n,
  input  bc_pkg::bc_mdu_req_t        req,
  input  logic [bc_pkg::ACC_W-1:0]   operand,
  output bc_pkg::bc_mdu_rsp_t        rsp,
  output logic [bc_pkg::ACC_W-1:0]   quotient
);
  import bc_pkg::*;

  typedef enum logic [1:0] {PH_IDLE, PH_MUL, PH_DIV} phase_t;

  phase_t             phase_r, phase_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [ACC_W-1:0]   mcand_r, mcand_nxt;
  logic [ROW_W-1:0]   mplier_r, mplier_nxt;
  logic [ACC_W-1:0]   work_r, work_nxt;
  logic [IDX_W-1:0]   rem_r, rem_nxt;
  logic [IDX_W-1:0]   div_r, div_nxt;
  logic               done_r, done_nxt;
  logic [IDX_W:0]     trial;
  logic               qbit;

  assign trial = {rem_r, work_r[ACC_W-1]};
  assign qbit  = (trial >= {1'b0, div_r});

  always_comb begin
    phase_nxt  = phase_r;
    cnt_nxt    = cnt_r;
    mcand_nxt  = mcand_r;
    mplier_nxt = mplier_r;
    work_nxt   = work_r;
    rem_nxt    = rem_r;
    div_nxt    = div_r;
    done_nxt   = 1'b0;
    case (phase_r)
      PH_IDLE: begin
        if (req.start) begin
          phase_nxt  = PH_MUL;
          cnt_nxt    = MUL_LAST;
          mcand_nxt  = operand;
          mplier_nxt = req.factor;
          work_nxt   = '0;
          div_nxt    = req.divisor;
        end
      end
      PH_MUL: begin
        // Shift-and-add, one multiplier bit per cycle.
        if (mplier_r[0]) begin
          work_nxt = work_r + mcand_r;
        end
        mcand_nxt  = {mcand_r[ACC_W-2:0], 1'b0};
        mplier_nxt = {1'b0, mplier_r[ROW_W-1:1]};
        if (cnt_r == '0) begin
          phase_nxt = PH_DIV;
          cnt_nxt   = DIV_LAST;
          rem_nxt   = '0;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      PH_DIV: begin
        // Restoring division: dividend bits leave at the top while
        // quotient bits enter at the bottom of the same register.
        if (qbit) begin
          rem_nxt = IDX_W'(trial - {1'b0, div_r});
        end else begin
          rem_nxt = trial[IDX_W-1:0];
        end
        work_nxt = {work_r[ACC_W-2:0], qbit};
        if (cnt_r == '0) begin
          phase_nxt = PH_IDLE;
          done_nxt  = 1'b1;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      done_r  <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      done_r  <= done_nxt;
    end
    cnt_r    <= cnt_nxt;
    mcand_r  <= mcand_nxt;
    mplier_r <= mplier_nxt;
    work_r   <= work_nxt;
    rem_r    <= rem_nxt;
    div_r    <= div_nxt;
  end

  assign rsp.busy = (phase_r != PH_IDLE);
  assign rsp.done = done_r;
  assign quotient = work_r;

endmodule
